// ----- rtl/oisd_pkg.sv -----
package oisd_pkg;

    // Header layout
    localparam int unsigned HEADER_BYTES = 32;
    localparam int unsigned POS_W        = 36;

    localparam logic [POS_W-1:0] POS_MAGIC_END   = POS_W'(7);
    localparam logic [POS_W-1:0] POS_VERSION_END = POS_W'(11);
    localparam logic [POS_W-1:0] POS_HSIZE_END   = POS_W'(15);
    localparam logic [POS_W-1:0] POS_COUNT_END   = POS_W'(23);
    localparam logic [POS_W-1:0] POS_HEADER_END  = POS_W'(HEADER_BYTES - 1);
    localparam logic [POS_W-1:0] POS_HEADER_LEN  = POS_W'(HEADER_BYTES);
    localparam logic [POS_W-1:0] POS_MAX         = {POS_W{1'b1}};

    // "MVGOWNR" followed by a zero byte, little endian
    localparam logic [63:0] MAGIC_WORD = 64'h0052_4E57_4F47_564D;
    localparam logic [31:0] HSIZE_WORD = 32'(HEADER_BYTES);

    // Status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_ZERO_LIMIT = 3'd1;
    localparam logic [2:0] ST_TRUNCATED  = 3'd2;
    localparam logic [2:0] ST_MAGIC      = 3'd3;
    localparam logic [2:0] ST_VERSION    = 3'd4;
    localparam logic [2:0] ST_HEADER     = 3'd5;
    localparam logic [2:0] ST_OVER_LIMIT = 3'd6;
    localparam logic [2:0] ST_LENGTH     = 3'd7;

    // Configuration registers
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_OWNERS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_EXP_VERSION = 1'b1;
    localparam logic [31:0] MAX_OWNERS_RST  = 32'd1048576;
    localparam logic [31:0] EXP_VERSION_RST = 32'd1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } in_beat_t;

    typedef struct packed {
        logic        has_owner;
        logic [63:0] owner_id;
        logic        is_final;
        logic [2:0]  status;
    } result_t;

endpackage

// ----- rtl/oisd_in_stage.sv -----
module oisd_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,
    input  logic              s_tlast,
    input  logic              advance,
    output logic              beat_valid,
    output oisd_pkg::in_beat_t beat
);
    import oisd_pkg::*;

    logic     valid_reg;
    in_beat_t beat_reg;

    // Room when empty or when the held beat moves on this cycle
    assign s_tready   = !valid_reg || advance;
    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            beat_reg.data_byte     <= s_tdata;
            beat_reg.end_of_buffer <= s_tlast;
        end
    end

endmodule

// ----- rtl/oisd_parser.sv -----
module oisd_parser (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [oisd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data,
    input  logic                          beat_valid,
    input  oisd_pkg::in_beat_t            beat,
    input  logic                          out_free,
    output logic                          advance,
    output logic                          res_load,
    output oisd_pkg::result_t             res
);
    import oisd_pkg::*;

    logic [31:0]      max_owners_reg;
    logic [31:0]      exp_version_reg;

    logic [POS_W-1:0] pos_reg,    pos_next;
    logic [63:0]      shift_reg,  shift_next;
    logic [63:0]      count_reg,  count_next;
    logic [32:0]      owners_reg, owners_next;
    logic [2:0]       err_reg,    err_next;
    logic             hok_reg,    hok_next;

    logic [2:0]       lane;
    logic [63:0]      shift_base;
    logic             emit;
    logic             over_limit;
    logic [POS_W-1:0] pos_inc;
    logic [POS_W-1:0] len_body;
    logic             length_ok;
    logic [2:0]       final_status;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_owners_reg  <= MAX_OWNERS_RST;
            exp_version_reg <= EXP_VERSION_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAX_OWNERS:  max_owners_reg  <= cfg_data;
                REG_EXP_VERSION: exp_version_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign advance = beat_valid && out_free;

    // Byte assembly
    assign lane       = pos_reg[2:0];
    assign shift_base = (lane == 3'd0) ? 64'd0 : shift_reg;
    assign shift_next = shift_base | ({56'd0, beat.data_byte} << {lane, 3'b000});
    assign pos_inc    = (pos_reg != POS_MAX) ? pos_reg + POS_W'(1) : pos_reg;

    assign over_limit = (count_reg[63:32] != 32'd0) || (count_reg[31:0] > max_owners_reg);

    assign emit = (pos_reg >= POS_HEADER_LEN) && (lane == 3'd7) && hok_reg &&
                  ({31'd0, owners_reg} < count_reg);

    // Header checks (first error wins), declared count capture, emitted owner count
    always_comb
    begin
        err_next    = err_reg;
        count_next  = count_reg;
        hok_next    = hok_reg;
        owners_next = owners_reg;
        if (pos_reg == POS_MAGIC_END)
        begin
            if (shift_next != MAGIC_WORD && err_reg == ST_OK)
                err_next = ST_MAGIC;
        end
        else if (pos_reg == POS_VERSION_END)
        begin
            if (shift_next[31:0] != exp_version_reg && err_reg == ST_OK)
                err_next = ST_VERSION;
        end
        else if (pos_reg == POS_HSIZE_END)
        begin
            if (shift_next[63:32] != HSIZE_WORD && err_reg == ST_OK)
                err_next = ST_HEADER;
        end
        else if (pos_reg == POS_COUNT_END)
        begin
            count_next = shift_next;
        end
        else if (pos_reg == POS_HEADER_END)
        begin
            if (err_reg == ST_OK)
            begin
                if (shift_next != 64'd0)
                    err_next = ST_HEADER;
                else if (over_limit)
                    err_next = ST_OVER_LIMIT;
            end
            hok_next = (err_next == ST_OK);
        end
        else if (emit)
        begin
            owners_next = owners_reg + 33'd1;
        end
    end

    // Length must equal header plus eight bytes per declared owner (mod 2^64)
    assign len_body  = pos_inc - POS_HEADER_LEN;
    assign length_ok = (len_body[2:0] == 3'd0) && (count_next[60:33] == 28'd0) &&
                       (count_next[32:0] == len_body[POS_W-1:3]);

    always_comb
    begin
        if (max_owners_reg == 32'd0)
            final_status = ST_ZERO_LIMIT;
        else if (pos_inc < POS_HEADER_LEN)
            final_status = ST_TRUNCATED;
        else if (err_next != ST_OK)
            final_status = err_next;
        else if (!length_ok)
            final_status = ST_LENGTH;
        else
            final_status = ST_OK;
    end

    // Result for this beat
    assign res_load      = advance && (emit || beat.end_of_buffer);
    assign res.has_owner = emit;
    assign res.owner_id  = emit ? shift_next : 64'd0;
    assign res.is_final  = beat.end_of_buffer;
    assign res.status    = beat.end_of_buffer ? final_status : ST_OK;

    // Stream state, cleared after the final byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            shift_reg  <= '0;
            count_reg  <= '0;
            owners_reg <= '0;
            err_reg    <= ST_OK;
            hok_reg    <= 1'b0;
        end
        else if (advance)
        begin
            if (beat.end_of_buffer)
            begin
                pos_reg    <= '0;
                shift_reg  <= '0;
                count_reg  <= '0;
                owners_reg <= '0;
                err_reg    <= ST_OK;
                hok_reg    <= 1'b0;
            end
            else
            begin
                pos_reg    <= pos_inc;
                shift_reg  <= shift_next;
                count_reg  <= count_next;
                owners_reg <= owners_next;
                err_reg    <= err_next;
                hok_reg    <= hok_next;
            end
        end
    end

    a_clear_after_final: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && beat.end_of_buffer) |=> (pos_reg == '0 && !hok_reg))
        else $error("stream state not cleared after final byte");

    a_owner_needs_header: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && emit) |-> (hok_reg && err_reg == ST_OK))
        else $error("owner emitted without a valid header");

    a_owner_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ({31'd0, owners_reg} <= count_reg))
        else $error("more owners emitted than declared");

endmodule

// ----- rtl/oisd_out_stage.sv -----
module oisd_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              res_load,
    input  oisd_pkg::result_t res,
    output logic              out_free,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [71:0]       m_tdata,
    output logic              m_tuser,
    output logic              m_tlast
);
    import oisd_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    assign out_free = !valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            valid_reg <= res_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && res_load)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {5'd0, res_reg.status, res_reg.owner_id};
    assign m_tuser  = res_reg.has_owner;
    assign m_tlast  = res_reg.is_final;

    a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser || m_tlast))
        else $error("result beat with neither owner nor final flag");

    a_status_only_final: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> (m_tdata[66:64] == ST_OK))
        else $error("nonzero status on a non-final beat");

endmodule

// ----- rtl/owner_id_sidecar_deframer_core.sv -----
// Owner-id sidecar deframer.
// Input stream s_*: one buffer byte per beat, s_tlast on the final byte.
// Output stream m_*: one beat per completed owner id (m_tuser = 1) and one
// beat for the final byte (m_tlast = 1, status in m_tdata[66:64]); a final
// byte that also completes an owner gives a single beat carrying both.
// Owners are sent before the verdict; drop them if the final status is
// nonzero (1 zero limit, 2 truncated, 3 magic, 4 version, 5 header,
// 6 over limit, 7 length).
// Configuration: cfg_we/cfg_index/cfg_data, index 0 max owner count,
// index 1 expected version; write only while the block is idle.
// Throughput: one byte per cycle while the output is not stalled; each
// byte passes through the input register, one pass of header/count logic,
// and the result register, which drives m_*.
// Reset: stream state clears, registers return to 1048576 and 1, and the
// block takes bytes in the first cycle after reset.
// If m_tready is low while the result register is full, it holds; an empty
// input register takes one more byte, then s_tready drops until the output drains.
module owner_id_sidecar_deframer_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [oisd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] data_byte
    input  logic                          s_tlast,   // end_of_buffer
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [71:0]                   m_tdata,   // [63:0] owner_id, [66:64] status
    output logic                          m_tuser,   // has_owner
    output logic                          m_tlast    // is_final
);
    import oisd_pkg::*;

    logic     advance;
    logic     beat_valid;
    in_beat_t beat;
    logic     out_free;
    logic     res_load;
    result_t  res;

    oisd_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .advance    (advance),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    oisd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .beat_valid (beat_valid),
        .beat       (beat),
        .out_free   (out_free),
        .advance    (advance),
        .res_load   (res_load),
        .res        (res)
    );

    oisd_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_load (res_load),
        .res      (res),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
